// File: rtl/bis_pkg.sv
package bis_pkg;

  // Item and register field widths
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 8;
  localparam int POS_W     = 24;
  localparam int WIN_W     = 16;
  localparam int DIM_W     = 9;
  localparam int STORE_AW  = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // Image size limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int IDX_W = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);

  // Signed coordinate relative to the window origin, with room for the +1 neighbor
  localparam int CRD_W = WIN_W + 2;

  // Configuration port
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MODE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_MIN_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_MIN_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

  // Opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Modes
  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;
  localparam logic BOUND_CLAMP     = 1'b0;
  localparam logic BOUND_ZERO      = 1'b1;

  localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

  // Size register as used: zero reads as one, anything past the limit as the limit
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/bilinear_image_sampler_top.sv
// Bilinear image sampler. Load the image with write items (opcode 0), one pixel at
// store index column + row * width; then send sample items (opcode 1) with a signed
// position carrying 8 fraction bits, and take one 16-bit value back per sample. The
// block takes one item per clock and passes a sample through stages s1 to s4 and
// the output register while out_stall stays low; a stall on the result side holds the
// whole pipeline and shows up on in_stall in the same cycle. The store is mirrored in
// two RAMs with two read ports each, so the four neighbors of a sample are read in a
// single cycle, and writes go into both copies in item order, so a sample sees every
// write sent ahead of it. Pixels must be written before they are sampled. Write the
// registers only while no item is in flight.
module bilinear_image_sampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [bis_pkg::STORE_AW-1:0]        in_pixel_address,
  input  logic [bis_pkg::SAMPLE_W-1:0]        in_pixel_value,
  input  logic signed [bis_pkg::POS_W-1:0]    in_sample_x,
  input  logic signed [bis_pkg::POS_W-1:0]    in_sample_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bis_pkg::SAMPLE_W-1:0]        out_sample_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bis_pkg::CFG_AW-1:0]          paddr,
  input  logic [bis_pkg::CFG_DW-1:0]          pwdata,
  output logic [bis_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int SAMPLE_W = bis_pkg::SAMPLE_W;
  localparam int FRAC_W   = bis_pkg::FRAC_W;
  localparam int POS_W    = bis_pkg::POS_W;
  localparam int WIN_W    = bis_pkg::WIN_W;
  localparam int DIM_W    = bis_pkg::DIM_W;
  localparam int AW       = bis_pkg::STORE_AW;
  localparam int IDX_W    = bis_pkg::IDX_W;
  localparam int CRD_W    = bis_pkg::CRD_W;
  localparam int WGT_W    = FRAC_W + 1;
  localparam int ROW_W    = IDX_W + DIM_W;
  localparam int TOP_W    = SAMPLE_W + FRAC_W;
  localparam int ACC_W    = TOP_W + WGT_W;
  localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             outside;
  } bnd_t;

  // Bring a coordinate into [0, dim-1] and flag whether it was outside
  function automatic bnd_t clamp_crd(input logic signed [CRD_W-1:0] v,
                                     input logic [DIM_W-1:0] dim);
    logic signed [CRD_W-1:0] lim;
    logic [DIM_W-1:0]        last;
    bnd_t                    r;
    lim  = $signed({{(CRD_W-DIM_W){1'b0}}, dim});
    last = dim - DIM_W'(1);
    if (v < 0) begin
      r.idx     = '0;
      r.outside = 1'b1;
    end else if (v >= lim) begin
      r.idx     = last[IDX_W-1:0];
      r.outside = 1'b1;
    end else begin
      r.idx     = v[IDX_W-1:0];
      r.outside = 1'b0;
    end
    return r;
  endfunction

  // Configuration registers
  logic                    filter_mode_r;
  logic                    bound_mode_r;
  logic [WIN_W-1:0]        window_min_x_r;
  logic [WIN_W-1:0]        window_min_y_r;
  logic [DIM_W-1:0]        image_width_r;
  logic [DIM_W-1:0]        image_height_r;
  logic                    cfg_wr;
  logic [bis_pkg::REG_IDX_W-1:0] reg_idx;

  // Pipeline control
  logic adv;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_valid_r;

  // Stage 1: item as transferred
  logic                    s1_op_r;
  logic [AW-1:0]           s1_waddr_r;
  logic [SAMPLE_W-1:0]     s1_wval_r;
  logic [POS_W-1:0]        s1_x_r;
  logic [POS_W-1:0]        s1_y_r;

  // Stage 2: clamped neighbor coordinates
  logic                    s2_op_r;
  logic [AW-1:0]           s2_waddr_r;
  logic [SAMPLE_W-1:0]     s2_wval_r;
  logic [IDX_W-1:0]        s2_xa_r, s2_xb_r, s2_ya_r, s2_yb_r;
  logic [3:0]              s2_zero_r;
  logic [FRAC_W-1:0]       s2_fx_r, s2_fy_r;

  // Stage 3: pixels come out of the RAMs
  logic [3:0]              s3_zero_r;
  logic [FRAC_W-1:0]       s3_fx_r, s3_fy_r;

  // Stage 4: horizontal blend done
  logic [TOP_W-1:0]        s4_top_r, s4_bot_r;
  logic [FRAC_W-1:0]       s4_fy_r;

  logic [SAMPLE_W-1:0]     out_value_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[bis_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      bis_pkg::REG_FILTER_MODE:  prdata = {{(bis_pkg::CFG_DW-1){1'b0}}, filter_mode_r};
      bis_pkg::REG_BOUND_MODE:   prdata = {{(bis_pkg::CFG_DW-1){1'b0}}, bound_mode_r};
      bis_pkg::REG_WINDOW_MIN_X: prdata = {{(bis_pkg::CFG_DW-WIN_W){1'b0}}, window_min_x_r};
      bis_pkg::REG_WINDOW_MIN_Y: prdata = {{(bis_pkg::CFG_DW-WIN_W){1'b0}}, window_min_y_r};
      bis_pkg::REG_IMAGE_WIDTH:  prdata = {{(bis_pkg::CFG_DW-DIM_W){1'b0}}, image_width_r};
      bis_pkg::REG_IMAGE_HEIGHT: prdata = {{(bis_pkg::CFG_DW-DIM_W){1'b0}}, image_height_r};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= bis_pkg::FILTER_BILINEAR;
      bound_mode_r   <= bis_pkg::BOUND_CLAMP;
      window_min_x_r <= '0;
      window_min_y_r <= '0;
      image_width_r  <= bis_pkg::MAX_WIDTH_DIM;
      image_height_r <= bis_pkg::MAX_HEIGHT_DIM;
      s1_vld_r       <= 1'b0;
      s2_vld_r       <= 1'b0;
      s3_vld_r       <= 1'b0;
      s4_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          bis_pkg::REG_FILTER_MODE:  filter_mode_r  <= pwdata[0];
          bis_pkg::REG_BOUND_MODE:   bound_mode_r   <= pwdata[0];
          bis_pkg::REG_WINDOW_MIN_X: window_min_x_r <= pwdata[WIN_W-1:0];
          bis_pkg::REG_WINDOW_MIN_Y: window_min_y_r <= pwdata[WIN_W-1:0];
          bis_pkg::REG_IMAGE_WIDTH:  image_width_r  <= pwdata[DIM_W-1:0];
          bis_pkg::REG_IMAGE_HEIGHT: image_height_r <= pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        s1_vld_r    <= in_valid;
        s2_vld_r    <= s1_vld_r;
        // writes leave the pipeline here: they give no result
        s3_vld_r    <= s2_vld_r && (s2_op_r == bis_pkg::OP_SAMPLE);
        s4_vld_r    <= s3_vld_r;
        out_valid_r <= s4_vld_r;
      end
    end
  end

  // ---------------- stage 1: positions to neighbor coordinates ----------------
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic signed [WIN_W-1:0] flx, fly;
  logic [FRAC_W-1:0]       frx, fry;
  logic                    adjx, adjy;
  logic signed [CRD_W-1:0] xs, ys, x1, y1, x2, y2;
  bnd_t                    bxa, bxb, bya, byb;
  logic                    bzero;
  logic                    nearest;
  logic [3:0]              zero_nxt;
  logic [FRAC_W-1:0]       fx_nxt, fy_nxt;

  assign w_eff = bis_pkg::eff_dim(image_width_r, bis_pkg::MAX_WIDTH_DIM);
  assign h_eff = bis_pkg::eff_dim(image_height_r, bis_pkg::MAX_HEIGHT_DIM);

  always_comb begin
    flx  = s1_x_r[POS_W-1:FRAC_W];
    fly  = s1_y_r[POS_W-1:FRAC_W];
    frx  = s1_x_r[FRAC_W-1:0];
    fry  = s1_y_r[FRAC_W-1:0];
    // in nearest mode a negative position with a fraction steps up by one from the floor, toward zero
    adjx = (filter_mode_r == bis_pkg::FILTER_NEAREST) && s1_x_r[POS_W-1] && (frx != '0);
    adjy = (filter_mode_r == bis_pkg::FILTER_NEAREST) && s1_y_r[POS_W-1] && (fry != '0);
    xs   = {{(CRD_W-WIN_W){flx[WIN_W-1]}}, flx} + {{(CRD_W-1){1'b0}}, adjx};
    ys   = {{(CRD_W-WIN_W){fly[WIN_W-1]}}, fly} + {{(CRD_W-1){1'b0}}, adjy};
    x1   = xs - {{(CRD_W-WIN_W){window_min_x_r[WIN_W-1]}}, window_min_x_r};
    y1   = ys - {{(CRD_W-WIN_W){window_min_y_r[WIN_W-1]}}, window_min_y_r};
    x2   = x1 + CRD_W'(1);
    y2   = y1 + CRD_W'(1);
    bxa  = clamp_crd(x1, w_eff);
    bxb  = clamp_crd(x2, w_eff);
    bya  = clamp_crd(y1, h_eff);
    byb  = clamp_crd(y2, h_eff);
    bzero = (bound_mode_r == bis_pkg::BOUND_ZERO);
    // nearest mode reads one pixel: drop the other three, they may never have been written
    nearest = (filter_mode_r == bis_pkg::FILTER_NEAREST);
    zero_nxt[0] = bzero && (bxa.outside || bya.outside);
    zero_nxt[1] = nearest || (bzero && (bxb.outside || bya.outside));
    zero_nxt[2] = nearest || (bzero && (bxa.outside || byb.outside));
    zero_nxt[3] = nearest || (bzero && (bxb.outside || byb.outside));
    // nearest mode runs through the blend with zero weight on the far neighbors
    if (filter_mode_r == bis_pkg::FILTER_BILINEAR) begin
      fx_nxt = frx;
      fy_nxt = fry;
    end else begin
      fx_nxt = '0;
      fy_nxt = '0;
    end
  end

  // ---------------- stage 2: store addresses ----------------
  logic [ROW_W-1:0] row_a, row_b;
  logic [ROW_W-1:0] addr_a, addr_b, addr_c, addr_d;
  logic             ram_we;
  logic [SAMPLE_W-1:0] px_a, px_b, px_c, px_d;

  always_comb begin
    row_a  = {{DIM_W{1'b0}}, s2_ya_r} * {{IDX_W{1'b0}}, w_eff};
    row_b  = {{DIM_W{1'b0}}, s2_yb_r} * {{IDX_W{1'b0}}, w_eff};
    addr_a = row_a + {{DIM_W{1'b0}}, s2_xa_r};
    addr_b = row_a + {{DIM_W{1'b0}}, s2_xb_r};
    addr_c = row_b + {{DIM_W{1'b0}}, s2_xa_r};
    addr_d = row_b + {{DIM_W{1'b0}}, s2_xb_r};
  end

  assign ram_we = adv && s2_vld_r && (s2_op_r == bis_pkg::OP_WRITE);

  bis_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(bis_pkg::STORE_DEPTH)
  ) u_ram_upper (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (s2_waddr_r),
    .wdata  (s2_wval_r),
    .re     (adv),
    .raddr0 (addr_a[AW-1:0]),
    .raddr1 (addr_b[AW-1:0]),
    .rdata0 (px_a),
    .rdata1 (px_b)
  );

  bis_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(bis_pkg::STORE_DEPTH)
  ) u_ram_lower (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (s2_waddr_r),
    .wdata  (s2_wval_r),
    .re     (adv),
    .raddr0 (addr_c[AW-1:0]),
    .raddr1 (addr_d[AW-1:0]),
    .rdata0 (px_c),
    .rdata1 (px_d)
  );

  // ---------------- stage 3: blend along x ----------------
  logic [SAMPLE_W-1:0] va, vb, vc, vd;
  logic [WGT_W-1:0]    gx, fx9;
  logic [TOP_W:0]      top_sum, bot_sum;

  always_comb begin
    va  = s3_zero_r[0] ? '0 : px_a;
    vb  = s3_zero_r[1] ? '0 : px_b;
    vc  = s3_zero_r[2] ? '0 : px_c;
    vd  = s3_zero_r[3] ? '0 : px_d;
    fx9 = {1'b0, s3_fx_r};
    gx  = ONE - fx9;
    top_sum = ({{WGT_W{1'b0}}, va} * {{SAMPLE_W{1'b0}}, gx})
            + ({{WGT_W{1'b0}}, vb} * {{SAMPLE_W{1'b0}}, fx9});
    bot_sum = ({{WGT_W{1'b0}}, vc} * {{SAMPLE_W{1'b0}}, gx})
            + ({{WGT_W{1'b0}}, vd} * {{SAMPLE_W{1'b0}}, fx9});
  end

  // ---------------- stage 4: blend along y ----------------
  logic [WGT_W-1:0] gy, fy9;
  logic [ACC_W:0]   acc;

  always_comb begin
    fy9 = {1'b0, s4_fy_r};
    gy  = ONE - fy9;
    acc = ({{(WGT_W+1){1'b0}}, s4_top_r} * {{(TOP_W+1){1'b0}}, gy})
        + ({{(WGT_W+1){1'b0}}, s4_bot_r} * {{(TOP_W+1){1'b0}}, fy9});
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_opcode;
      s1_waddr_r <= in_pixel_address;
      s1_wval_r  <= in_pixel_value;
      s1_x_r     <= in_sample_x;
      s1_y_r     <= in_sample_y;

      s2_op_r    <= s1_op_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wval_r  <= s1_wval_r;
      s2_xa_r    <= bxa.idx;
      s2_xb_r    <= bxb.idx;
      s2_ya_r    <= bya.idx;
      s2_yb_r    <= byb.idx;
      s2_zero_r  <= zero_nxt;
      s2_fx_r    <= fx_nxt;
      s2_fy_r    <= fy_nxt;

      s3_zero_r  <= s2_zero_r;
      s3_fx_r    <= s2_fx_r;
      s3_fy_r    <= s2_fy_r;

      s4_top_r   <= top_sum[TOP_W-1:0];
      s4_bot_r   <= bot_sum[TOP_W-1:0];
      s4_fy_r    <= s3_fy_r;

      out_value_r <= acc[2*FRAC_W +: SAMPLE_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;

endmodule

// File: rtl/bis_ram.sv
module bis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// File: rtl/bis_checker.sv
module bis_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bis_pkg::SAMPLE_W-1:0] out_sample_value,
  input logic                         pready
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sample_value))
    else $error("stalled result changed");

  // Input side backs up only behind a held result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no held result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port not ready");

endmodule

bind bilinear_image_sampler_top bis_checker u_bis_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value),
  .pready           (pready)
);
